FILE: src/btsm_pkg.sv
// ----------------------------------------------------------------------------
// btsm_pkg
// Shared widths, codes and reset values of the binary template SAD matcher.
// ----------------------------------------------------------------------------
package btsm_pkg;

  // Default geometry, handed to the top level as parameter defaults
  localparam int DefTemplateSlots = 10;
  localparam int DefImageSide     = 60;

  // Fixed field widths
  localparam int SlotW   = 4;
  localparam int IndexW  = 12;
  localparam int PixelW  = 8;
  localparam int CountW  = 12;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 8;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Operation codes
  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgBinarizeLevel  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTemplatesInUse = 2'd1;

  // Register reset values
  localparam logic [PixelW-1:0] BinarizeLevelRst  = 8'd100;
  localparam logic [SlotW-1:0]  TemplatesInUseRst = 4'd10;

endpackage

FILE: src/btsm_ram.sv
// ----------------------------------------------------------------------------
// btsm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module btsm_ram #(
  parameter int Width = 1,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/binary_template_sad_matcher_top.sv
// ----------------------------------------------------------------------------
// binary_template_sad_matcher_top
// Binarized template store, per-slot mismatch counters and a minimum search.
// ----------------------------------------------------------------------------
// One word is taken every clock cycle (busy_o stays low) and the receiver
// cannot stall. A template write lands in the slot's bit RAM at the accepting
// edge. A query word reads all slots at its pixel position and updates the
// counters in the following cycle, and a query word marked last_pixel_i
// snapshots and clears the counters; the winner comes out of a registered
// pairwise minimum tree, so result_valid_o rises once the snapshot has passed
// the query stage, the leaf registers and each level of the tree.
// Template pixels read before they were written give
// undefined counts; there is no clearing pass.
module binary_template_sad_matcher_top #(
  parameter int TEMPLATE_SLOTS = btsm_pkg::DefTemplateSlots,
  parameter int IMAGE_SIDE     = btsm_pkg::DefImageSide
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // command channel
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        operation_i,
  input  logic [btsm_pkg::SlotW-1:0]  template_slot_i,
  input  logic [btsm_pkg::IndexW-1:0] pixel_index_i,
  input  logic [btsm_pkg::PixelW-1:0] pixel_value_i,
  input  logic                        last_pixel_i,
  // result
  output logic                        result_valid_o,
  output logic [btsm_pkg::SlotW-1:0]  best_template_o,
  output logic [btsm_pkg::CountW-1:0] mismatch_count_o,
  // configuration
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [btsm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [btsm_pkg::CfgW-1:0]   cfg_data_i
);

  localparam int Pixels = IMAGE_SIDE * IMAGE_SIDE;
  localparam int AddrW  = $clog2(Pixels);
  localparam int Levels = $clog2(TEMPLATE_SLOTS);
  localparam int Leaves = 1 << Levels;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [btsm_pkg::PixelW-1:0] bin_level_q;
  logic [btsm_pkg::SlotW-1:0]  tiu_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_level_q <= btsm_pkg::BinarizeLevelRst;
      tiu_q       <= btsm_pkg::TemplatesInUseRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        btsm_pkg::CfgBinarizeLevel:  bin_level_q <= cfg_data_i;
        btsm_pkg::CfgTemplatesInUse: tiu_q       <= cfg_data_i[btsm_pkg::SlotW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input word: binarize, write templates, launch reads
  // --------------------------------------------------------------------------
  logic                      accept;
  logic                      pix_bit;
  logic                      idx_ok;
  logic                      slot_ok;
  logic [AddrW-1:0]          addr;
  logic [TEMPLATE_SLOTS-1:0] tmpl_bits;

  assign busy_o  = 1'b0;
  assign accept  = start_i && !busy_o;
  assign pix_bit = pixel_value_i > bin_level_q;
  assign idx_ok  = 32'(pixel_index_i) < Pixels;
  assign slot_ok = 32'(template_slot_i) < TEMPLATE_SLOTS;
  assign addr    = AddrW'(pixel_index_i);

  for (genvar s = 0; s < TEMPLATE_SLOTS; s++) begin : g_ram
    logic we;
    assign we = accept && (operation_i == btsm_pkg::OpWrite) && idx_ok && slot_ok
                && (32'(template_slot_i) == s);
    btsm_ram #(
      .Width (1),
      .Depth (Pixels)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (addr),
      .wdata_i (pix_bit),
      .raddr_i (addr),
      .rdata_o (tmpl_bits[s])
    );
  end

  // query stage, aligned with the RAM read data
  logic q_valid_q, q_cmp_q, q_bit_q, q_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_valid_q <= 1'b0;
      q_cmp_q   <= 1'b0;
      q_last_q  <= 1'b0;
    end else begin
      q_valid_q <= accept && (operation_i == btsm_pkg::OpQuery);
      q_cmp_q   <= accept && (operation_i == btsm_pkg::OpQuery) && idx_ok;
      q_last_q  <= last_pixel_i;
    end
  end

  always_ff @(posedge clk_i) begin
    q_bit_q <= pix_bit;
  end

  // --------------------------------------------------------------------------
  // Mismatch counters and snapshot on the last query word
  // --------------------------------------------------------------------------
  logic                        snap;
  logic [btsm_pkg::CountW-1:0] cnt_q   [TEMPLATE_SLOTS];
  logic [btsm_pkg::CountW-1:0] lvl_cnt_q [Levels+1][Leaves];
  logic [btsm_pkg::SlotW-1:0]  lvl_idx_q [Levels+1][Leaves];
  logic [Levels:0]             lvl_valid_q;

  assign snap = q_valid_q && q_last_q;

  for (genvar s = 0; s < TEMPLATE_SLOTS; s++) begin : g_cnt
    logic                        used;
    logic                        miss;
    logic [btsm_pkg::CountW-1:0] cnt_d;

    // slot 0 is always compared; anything beyond the slot count is clipped
    assign used = (s == 0) ? 1'b1 : (5'(s) < {1'b0, tiu_q});
    assign miss = q_cmp_q && used && (tmpl_bits[s] != q_bit_q);

    always_comb begin
      cnt_d = cnt_q[s];
      if (miss && (cnt_q[s] != btsm_pkg::CountMax)) begin
        cnt_d = cnt_q[s] + 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cnt_q[s] <= '0;
      end else if (snap) begin
        cnt_q[s] <= '0;
      end else begin
        cnt_q[s] <= cnt_d;
      end
    end

    // unused slots enter the tree at full scale and lose every tie against a used slot
    always_ff @(posedge clk_i) begin
      lvl_cnt_q[0][s] <= used ? cnt_d : btsm_pkg::CountMax;
      lvl_idx_q[0][s] <= btsm_pkg::SlotW'(s);
    end
  end

  for (genvar s = TEMPLATE_SLOTS; s < Leaves; s++) begin : g_pad
    always_ff @(posedge clk_i) begin
      lvl_cnt_q[0][s] <= btsm_pkg::CountMax;
      lvl_idx_q[0][s] <= btsm_pkg::SlotW'(s);
    end
  end

  // --------------------------------------------------------------------------
  // Registered minimum tree, lower slot wins ties
  // --------------------------------------------------------------------------
  for (genvar k = 1; k <= Levels; k++) begin : g_lvl
    for (genvar j = 0; j < (Leaves >> k); j++) begin : g_node
      always_ff @(posedge clk_i) begin
        if (lvl_cnt_q[k-1][2*j+1] < lvl_cnt_q[k-1][2*j]) begin
          lvl_cnt_q[k][j] <= lvl_cnt_q[k-1][2*j+1];
          lvl_idx_q[k][j] <= lvl_idx_q[k-1][2*j+1];
        end else begin
          lvl_cnt_q[k][j] <= lvl_cnt_q[k-1][2*j];
          lvl_idx_q[k][j] <= lvl_idx_q[k-1][2*j];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_valid_q <= '0;
    end else begin
      lvl_valid_q <= {lvl_valid_q[Levels-1:0], snap};
    end
  end

  assign result_valid_o   = lvl_valid_q[Levels];
  assign best_template_o  = lvl_idx_q[Levels][0];
  assign mismatch_count_o = lvl_cnt_q[Levels][0];

endmodule

FILE: sim/tb_binary_template_sad_matcher_top.sv
// ----------------------------------------------------------------------------
// tb_binary_template_sad_matcher_top
// Self-checking bench for the binary template SAD matcher.
// ----------------------------------------------------------------------------
// Template and query words are sent through the command channel with random
// gaps. A model of the template store and the mismatch counters runs in the
// bench and queues the winner expected for each closing query word. Every
// result strobe is checked against the oldest queued winner. The bench covers
// directed corner cases, a sweep of register settings and random frames.
// Queries inside the image only touch pixel positions written in every slot.
// ----------------------------------------------------------------------------
module tb_binary_template_sad_matcher_top;
  import btsm_pkg::*;

  localparam int Slots       = DefTemplateSlots;
  localparam int Pixels      = DefImageSide * DefImageSide;
  localparam int MaxIndex    = (1 << IndexW) - 1;
  localparam int DrainCycles = 12;
  localparam int CycleLimit  = 400000;

  // register indexes with no register behind them
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

  typedef struct packed {
    logic [SlotW-1:0]  best;
    logic [CountW-1:0] count;
  } match_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic                operation_i;
  logic [SlotW-1:0]    template_slot_i;
  logic [IndexW-1:0]   pixel_index_i;
  logic [PixelW-1:0]   pixel_value_i;
  logic                last_pixel_i;
  logic                result_valid_o;
  logic [SlotW-1:0]    best_template_o;
  logic [CountW-1:0]   mismatch_count_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgW-1:0]     cfg_data_i;

  // bench copy of the block state
  logic [Slots-1:0]    tmpl_bits [Pixels];
  logic [CountW-1:0]   miss_cnt [Slots];
  logic [PixelW-1:0]   level_q;
  logic [SlotW-1:0]    in_use_q;

  match_t              expected_matches [$];
  match_t              head_match;
  int                  pool_idx [$];
  bit                  in_pool [Pixels];
  int                  errors;
  int                  results_seen;
  int                  items_sent;
  int                  cycle_cnt;
  bit                  burst_mode;

  binary_template_sad_matcher_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .operation_i      (operation_i),
    .template_slot_i  (template_slot_i),
    .pixel_index_i    (pixel_index_i),
    .pixel_value_i    (pixel_value_i),
    .last_pixel_i     (last_pixel_i),
    .result_valid_o   (result_valid_o),
    .best_template_o  (best_template_o),
    .mismatch_count_o (mismatch_count_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Update the store and counters for one accepted word; queue the winner on
  // a closing query word.
  function automatic void apply_pixel(input logic op, input logic [SlotW-1:0] slot,
                                      input logic [IndexW-1:0] idx,
                                      input logic [PixelW-1:0] val, input logic last);
    logic   pix_set;
    int     n;
    match_t m;
    pix_set = (val > level_q);
    n = (in_use_q == 0) ? 1 : ((in_use_q > Slots) ? Slots : int'(in_use_q));
    if (op == OpWrite) begin
      if (slot < Slots && idx < Pixels) tmpl_bits[idx][slot] = pix_set;
    end else begin
      if (idx < Pixels) begin
        for (int s = 0; s < n; s++) begin
          if (tmpl_bits[idx][s] != pix_set && miss_cnt[s] != CountMax)
            miss_cnt[s] = miss_cnt[s] + 1'b1;
        end
      end
      if (last) begin
        m.best  = '0;
        m.count = miss_cnt[0];
        for (int s = 1; s < n; s++) begin
          if (miss_cnt[s] < m.count) begin
            m.count = miss_cnt[s];
            m.best  = SlotW'(s);
          end
        end
        expected_matches = {expected_matches, m};
        for (int s = 0; s < Slots; s++) miss_cnt[s] = '0;
      end
    end
  endfunction

  function automatic logic [PixelW-1:0] grey_near_level();
    case ($urandom_range(0, 3))
      0:       return level_q;
      1:       return level_q + 1'b1;
      default: return PixelW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [IndexW-1:0] pick_pool_index();
    return IndexW'(pool_idx[$urandom_range(0, pool_idx.size() - 1)]);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (expected_matches.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual slot %0d count %0d",
                 $time, best_template_o, mismatch_count_o);
        errors++;
      end else begin
        head_match = expected_matches.pop_front();
        if (best_template_o !== head_match.best) begin
          $display("%0t: best_template mismatch, expected %0d, actual %0d",
                   $time, head_match.best, best_template_o);
          errors++;
        end
        if (mismatch_count_o !== head_match.count) begin
          $display("%0t: mismatch_count mismatch, expected %0d, actual %0d",
                   $time, head_match.count, mismatch_count_o);
          errors++;
        end
      end
    end
  end

  task automatic send_pixel(input logic op, input logic [SlotW-1:0] slot,
                            input logic [IndexW-1:0] idx,
                            input logic [PixelW-1:0] val, input logic last);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 6);
    @(negedge clk_i);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i         <= 1'b1;
    operation_i     <= op;
    template_slot_i <= slot;
    pixel_index_i   <= idx;
    pixel_value_i   <= val;
    last_pixel_i    <= last;
    do @(posedge clk_i); while (busy_o);
    apply_pixel(op, slot, idx, val, last);
    items_sent++;
  endtask

  // Drop start and let every pending result come out.
  task automatic wait_drained();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      CfgBinarizeLevel:  level_q  = data;
      CfgTemplatesInUse: in_use_q = data[SlotW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Write one fresh pixel position in every slot so queries may read it.
  task automatic fill_new_index();
    int idx;
    do idx = $urandom_range(0, Pixels - 1); while (in_pool[idx]);
    for (int s = 0; s < Slots; s++)
      send_pixel(OpWrite, SlotW'(s), IndexW'(idx), PixelW'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
    in_pool[idx] = 1'b1;
    pool_idx = {pool_idx, idx};
  endtask

  task automatic run_query_frame(input int len);
    logic [IndexW-1:0] idx;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_pixel(OpWrite, SlotW'($urandom_range(0, Slots - 1)), pick_pool_index(),
                   grey_near_level(), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 11) == 0) idx = IndexW'($urandom_range(Pixels, MaxIndex));
      else idx = pick_pool_index();
      send_pixel(OpQuery, SlotW'($urandom_range(0, 15)), idx, grey_near_level(),
                 i == len - 1);
    end
  endtask

  task automatic test_directed_corners();
    // odd slots set at the first pixel, slots 0..4 set at the last one
    for (int s = 0; s < Slots; s++)
      send_pixel(OpWrite, SlotW'(s), '0, (s % 2) ? 8'd255 : 8'd0, s == 3);
    for (int s = 0; s < Slots; s++)
      send_pixel(OpWrite, SlotW'(s), IndexW'(Pixels - 1), (s < 5) ? 8'd101 : 8'd100, 1'b0);
    in_pool[0] = 1'b1;
    in_pool[Pixels - 1] = 1'b1;
    pool_idx = {pool_idx, 0};
    pool_idx = {pool_idx, Pixels - 1};
    // writes to a missing slot or past the image land nowhere
    send_pixel(OpWrite, 4'd15, '0, 8'd0, 1'b0);
    send_pixel(OpWrite, 4'd0, IndexW'(MaxIndex), 8'd0, 1'b0);
    send_pixel(OpQuery, 4'd0, '0, 8'd255, 1'b0);
    send_pixel(OpQuery, 4'd9, IndexW'(Pixels - 1), 8'd100, 1'b0);
    send_pixel(OpQuery, 4'd15, IndexW'(MaxIndex), 8'd0, 1'b1);
    // even slots tie at zero
    send_pixel(OpQuery, 4'd0, '0, 8'd0, 1'b1);
    send_pixel(OpQuery, 4'd0, IndexW'(Pixels - 1), 8'd255, 1'b1);
  endtask

  task automatic sweep_setting(input logic [CfgW-1:0] lvl, input logic [CfgW-1:0] n);
    wait_drained();
    write_reg(CfgBinarizeLevel, lvl);
    write_reg(CfgTemplatesInUse, n);
    fill_new_index();
    run_query_frame(6);
  endtask

  task automatic test_register_sweep();
    sweep_setting(8'd0, 8'd1);
    sweep_setting(8'd255, 8'd10);
    sweep_setting(8'd0, 8'd0);
    sweep_setting(8'd255, 8'd15);
    sweep_setting(8'd100, 8'hF3);
    sweep_setting(8'd128, 8'd2);
    wait_drained();
    write_reg(CfgSpareLo, 8'hFF);
    write_reg(CfgSpareHi, 8'h5A);
    run_query_frame(4);
  endtask

  task automatic test_random_frames();
    int start_items;
    int start_results;
    start_items   = items_sent;
    start_results = results_seen;
    while (items_sent - start_items < 420 || results_seen - start_results < 25) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      if (pool_idx.size() < 6 || $urandom_range(0, 3) == 0) fill_new_index();
      repeat ($urandom_range(0, 2))
        send_pixel(OpWrite, SlotW'($urandom_range(0, Slots - 1)), pick_pool_index(),
                   PixelW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 4) == 0) begin
        if ($urandom_range(0, 1))
          send_pixel(OpWrite, SlotW'($urandom_range(Slots, 15)), pick_pool_index(),
                     PixelW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        else
          send_pixel(OpWrite, SlotW'($urandom_range(0, 15)),
                     IndexW'($urandom_range(Pixels, MaxIndex)),
                     PixelW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      run_query_frame($urandom_range(1, 16));
      if ($urandom_range(0, 5) == 0) begin
        wait_drained();
        if ($urandom_range(0, 1)) write_reg(CfgBinarizeLevel, CfgW'($urandom_range(0, 255)));
        else write_reg(CfgTemplatesInUse, CfgW'($urandom_range(0, 15)));
      end
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    operation_i     = OpWrite;
    template_slot_i = '0;
    pixel_index_i   = '0;
    pixel_value_i   = '0;
    last_pixel_i    = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CfgBinarizeLevel;
    cfg_data_i      = '0;
    errors          = 0;
    results_seen    = 0;
    items_sent      = 0;
    cycle_cnt       = 0;
    burst_mode      = 1'b0;
    level_q         = BinarizeLevelRst;
    in_use_q        = TemplatesInUseRst;
    for (int s = 0; s < Slots; s++) miss_cnt[s] = '0;
    for (int p = 0; p < Pixels; p++) in_pool[p] = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_corners();
    test_register_sweep();
    test_random_frames();

    wait_drained();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
